// ===== design/rcc_pkg.sv =====
// rcc_pkg: shared types, constants and the output clamp for rgb_convolution_clamp
// no dependencies; every design file refers to it by scoped names
package rcc_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int DEF_KSIZE      = 3;

   localparam int CHAN_W    = 8;
   localparam int PIX_W     = 3 * CHAN_W;
   localparam int CHANNELS  = 3;
   localparam int COEF_W    = 16;
   localparam int FRAC_BITS = 11;
   localparam int KDIM      = 3;
   localparam int TAPS      = KDIM * KDIM;
   localparam int PROD_W    = CHAN_W + 1 + COEF_W;
   localparam int SUM_W     = PROD_W + 4;

   localparam int CFG_W       = 48;
   localparam int SIZE_W      = 11;
   localparam int CSR_INDEX_W = 3;
   localparam int QUEUE_DEPTH = 8;

   localparam logic [CHAN_W-1:0] PIX_MAX = 8'd255;

   localparam logic [SIZE_W-1:0] WIDTH_RESET  = 11'd1024;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = 11'd1024;
   localparam logic [CFG_W-1:0]  KROW_TOP_RESET    = 48'd0;
   localparam logic [CFG_W-1:0]  KROW_MIDDLE_RESET = 48'd134217728;
   localparam logic [CFG_W-1:0]  KROW_BOTTOM_RESET = 48'd0;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KROW_TOP      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KROW_MIDDLE   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_KROW_BOTTOM   = 3'd4;

   localparam logic OP_PUSH  = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic emit;
      logic last;
      logic top_ok;
      logic bottom_ok;
      logic left_ok;
      logic right_ok;
   } tap_ctl_type;

   typedef struct packed {
      pixel_type pixel;
      logic      last;
   } result_type;

   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic [CFG_W-1:0] krow_type;

   function automatic logic [CHAN_W-1:0] clamp_channel(input logic signed [SUM_W-1:0] sum);
      logic [SUM_W-1:0]  mag;
      logic [CHAN_W-1:0] res;
      mag = sum;
      if (sum < 0) begin
         res = '0;
      end else if (|mag[SUM_W-2:FRAC_BITS+CHAN_W]) begin
         res = PIX_MAX;
      end else begin
         res = mag[FRAC_BITS+CHAN_W-1:FRAC_BITS];
      end
      return res;
   endfunction

endpackage

// ===== design/rcc_line_buf.sv =====
// rcc_line_buf: line memory holding the two rows above the incoming pixel, per column
// depends on rcc_pkg; one read and one write per cycle, read data registered
module rcc_line_buf #(
   parameter int DEPTH = rcc_pkg::DEF_MAX_WIDTH,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic               clock,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  rcc_pkg::pixel_type wr_pixel,
   output rcc_pkg::pixel_type rd_upper,
   output rcc_pkg::pixel_type rd_middle
);

   logic [2*rcc_pkg::PIX_W-1:0] mem [DEPTH];
   logic [2*rcc_pkg::PIX_W-1:0] rd_ff;
   logic [2*rcc_pkg::PIX_W-1:0] wr_data;

   // the row above moves up one slot, the new pixel takes its place
   assign wr_data = {rd_ff[rcc_pkg::PIX_W-1:0], wr_pixel};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_ff <= wr_data;
         end else begin
            rd_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_upper  = rd_ff[2*rcc_pkg::PIX_W-1:rcc_pkg::PIX_W];
   assign rd_middle = rd_ff[rcc_pkg::PIX_W-1:0];

endmodule

// ===== design/rcc_tap_mult.sv =====
// rcc_tap_mult: 3x3 pixel window and the registered tap products for all channels
// depends on rcc_pkg; edge flags in the control struct give the zero padding
module rcc_tap_mult #(
   parameter int KSIZE = rcc_pkg::DEF_KSIZE
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift_en,
   input  rcc_pkg::pixel_type   col_upper,
   input  rcc_pkg::pixel_type   col_middle,
   input  rcc_pkg::pixel_type   col_lower,
   input  rcc_pkg::tap_ctl_type ctl_in,
   input  rcc_pkg::krow_type    kernel [rcc_pkg::KDIM],
   output logic                 stage_emit,
   output rcc_pkg::tap_ctl_type ctl_out,
   output rcc_pkg::prod_type    products [rcc_pkg::CHANNELS][rcc_pkg::TAPS]
);

   localparam int HALF   = KSIZE / 2;
   localparam int CENTER = rcc_pkg::KDIM / 2;

   rcc_pkg::pixel_type   win_ff [rcc_pkg::KDIM][rcc_pkg::KDIM];
   rcc_pkg::pixel_type   col_in [rcc_pkg::KDIM];
   rcc_pkg::tap_ctl_type b_ctl_ff;
   rcc_pkg::tap_ctl_type c_ctl_ff;
   rcc_pkg::prod_type    prod_in [rcc_pkg::CHANNELS][rcc_pkg::TAPS];
   rcc_pkg::prod_type    prod_ff [rcc_pkg::CHANNELS][rcc_pkg::TAPS];

   assign col_in[0] = col_upper;
   assign col_in[1] = col_middle;
   assign col_in[2] = col_lower;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         for (int t = 0; t < rcc_pkg::KDIM; t++) begin
            for (int u = 0; u < rcc_pkg::KDIM - 1; u++) begin
               win_ff[t][u] <= win_ff[t][u+1];
            end
            win_ff[t][rcc_pkg::KDIM-1] <= col_in[t];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ctl_ff <= '0;
         c_ctl_ff <= '0;
      end else begin
         b_ctl_ff <= ctl_in;
         c_ctl_ff <= b_ctl_ff;
      end
   end

   always_comb begin
      rcc_pkg::pixel_type                src;
      logic signed [rcc_pkg::COEF_W-1:0] coef;
      logic [rcc_pkg::CHAN_W-1:0]        chan;
      logic                              en;
      for (int t = 0; t < rcc_pkg::KDIM; t++) begin
         for (int u = 0; u < rcc_pkg::KDIM; u++) begin
            en = (t != 0 || b_ctl_ff.top_ok) && (t != rcc_pkg::KDIM - 1 || b_ctl_ff.bottom_ok) &&
                 (u != 0 || b_ctl_ff.left_ok) && (u != rcc_pkg::KDIM - 1 || b_ctl_ff.right_ok);
            src = win_ff[t][u];
            // single tap kernel: the newest pixel is the center
            if (HALF == 0) begin
               en  = (t == CENTER) && (u == CENTER);
               src = win_ff[rcc_pkg::KDIM-1][rcc_pkg::KDIM-1];
            end
            coef = kernel[t][rcc_pkg::COEF_W*u +: rcc_pkg::COEF_W];
            for (int ch = 0; ch < rcc_pkg::CHANNELS; ch++) begin
               chan = src[(rcc_pkg::CHANNELS-1-ch)*rcc_pkg::CHAN_W +: rcc_pkg::CHAN_W];
               prod_in[ch][t*rcc_pkg::KDIM+u] =
                  en ? rcc_pkg::PROD_W'($signed({1'b0, chan}) * coef) : '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign products   = prod_ff;
   assign ctl_out    = c_ctl_ff;
   assign stage_emit = b_ctl_ff.emit;

endmodule

// ===== design/rcc_sum_clamp.sv =====
// rcc_sum_clamp: adds the nine tap products of each channel and clamps to a pixel
// depends on rcc_pkg for types and the clamp function
module rcc_sum_clamp (
   input  rcc_pkg::prod_type  products [rcc_pkg::CHANNELS][rcc_pkg::TAPS],
   output rcc_pkg::pixel_type result
);

   always_comb begin
      logic signed [rcc_pkg::SUM_W-1:0] acc [rcc_pkg::CHANNELS];
      for (int ch = 0; ch < rcc_pkg::CHANNELS; ch++) begin
         acc[ch] = '0;
         for (int k = 0; k < rcc_pkg::TAPS; k++) begin
            acc[ch] = acc[ch] + rcc_pkg::SUM_W'(products[ch][k]);
         end
      end
      result.red   = rcc_pkg::clamp_channel(acc[0]);
      result.green = rcc_pkg::clamp_channel(acc[1]);
      result.blue  = rcc_pkg::clamp_channel(acc[2]);
   end

endmodule

// ===== design/rcc_out_queue.sv =====
// rcc_out_queue: small result queue between the compute pipeline and the response port
// depends on rcc_pkg for the result type
module rcc_out_queue #(
   parameter int DEPTH = rcc_pkg::QUEUE_DEPTH,
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rcc_pkg::result_type push_data,
   input  logic                pop,
   output rcc_pkg::result_type head,
   output logic                not_empty,
   output logic [CW-1:0]       count
);

   rcc_pkg::result_type mem_ff [DEPTH];
   logic [PW-1:0]       wr_ptr_ff;
   logic [PW-1:0]       rd_ptr_ff;
   logic [CW-1:0]       count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         count_ff <= count_ff + CW'(push) - CW'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head      = mem_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

endmodule

// ===== design/rgb_convolution_clamp.sv =====
// rgb_convolution_clamp: top level, config registers, frame counters and pipeline control
// depends on rcc_pkg, rcc_line_buf, rcc_tap_mult, rcc_sum_clamp, rcc_out_queue
//
// Zero-padded 3x3 convolution of an RGB raster stream, one request per clock while req_ready holds.
// A pixel or drain request is accepted whenever req_ready is high; its result, if any,
// passes the first stage, the tap and product registers and an eight-entry queue to
// the response port, so a stalled response side does not stop requests until eight
// results are queued or in flight. A frame takes width*height pushes and then width+1
// drains, or width drains for a one-row frame; with a 3x3 kernel and a one-row frame the
// block holds off requests while it pads the stream after the last pixel. The two
// previous rows live in one MAX_WIDTH x 48 bit line memory with one read and one write
// per cycle; it needs no clearing after reset, since taps outside the frame are masked.
module rgb_convolution_clamp #(
   parameter int MAX_WIDTH  = rcc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = rcc_pkg::DEF_MAX_HEIGHT,
   parameter int KSIZE      = rcc_pkg::DEF_KSIZE
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_operation,
   input  logic [rcc_pkg::CHAN_W-1:0]      req_red_in,
   input  logic [rcc_pkg::CHAN_W-1:0]      req_green_in,
   input  logic [rcc_pkg::CHAN_W-1:0]      req_blue_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rcc_pkg::CHAN_W-1:0]      rsp_red_out,
   output logic [rcc_pkg::CHAN_W-1:0]      rsp_green_out,
   output logic [rcc_pkg::CHAN_W-1:0]      rsp_blue_out,
   output logic                            rsp_frame_end,
   input  logic                            csr_write_enable,
   input  logic [rcc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rcc_pkg::CFG_W-1:0]       csr_write_data
);

   localparam int HALF = KSIZE / 2;
   localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int HW   = $clog2(MAX_HEIGHT + 1);
   localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int SRW  = $clog2(MAX_HEIGHT + 2);
   localparam int QCW  = $clog2(rcc_pkg::QUEUE_DEPTH + 1);
   localparam int OCW  = $clog2(rcc_pkg::QUEUE_DEPTH + 4);

   // configuration
   logic [rcc_pkg::SIZE_W-1:0] width_ff;
   logic [rcc_pkg::SIZE_W-1:0] height_ff;
   rcc_pkg::krow_type          krow_ff [rcc_pkg::KDIM];
   logic [rcc_pkg::SIZE_W+WW-1:0] width_ext;
   logic [rcc_pkg::SIZE_W+HW-1:0] height_ext;
   logic [WW-1:0]              w_eff;
   logic [WW-1:0]              w_last;
   logic [HW-1:0]              h_eff;
   logic [HW-1:0]              h_last;

   // frame position
   logic [AW-1:0]  s_col_ff;
   logic [SRW-1:0] s_row_ff;
   logic [AW-1:0]  out_col_ff;
   logic [RW-1:0]  out_row_ff;
   logic           rx_done_ff;

   logic s_col_end, s_row_end, out_col_end, out_row_end;
   logic reached, pad_req, req_fire, is_drain;
   logic push_ok, drain_ok, adv, emit, last_emit, last_push;

   rcc_pkg::pixel_type   in_pix;
   rcc_pkg::tap_ctl_type a_ctl_in;

   // first pipeline stage
   logic                 a_adv_ff;
   rcc_pkg::tap_ctl_type a_ctl_ff;
   rcc_pkg::pixel_type   a_pix_ff;
   logic [AW-1:0]        a_col_ff;

   rcc_pkg::pixel_type   lb_upper;
   rcc_pkg::pixel_type   lb_middle;
   logic                 b_emit;
   rcc_pkg::tap_ctl_type c_ctl;
   rcc_pkg::prod_type    products [rcc_pkg::CHANNELS][rcc_pkg::TAPS];
   rcc_pkg::pixel_type   sum_pixel;
   rcc_pkg::result_type  q_push_data;
   rcc_pkg::result_type  q_head;
   logic [QCW-1:0]       q_count;
   logic [OCW-1:0]       occupancy;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= rcc_pkg::WIDTH_RESET;
         height_ff  <= rcc_pkg::HEIGHT_RESET;
         krow_ff[0] <= rcc_pkg::KROW_TOP_RESET;
         krow_ff[1] <= rcc_pkg::KROW_MIDDLE_RESET;
         krow_ff[2] <= rcc_pkg::KROW_BOTTOM_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            rcc_pkg::CSR_FRAME_WIDTH: begin
               width_ff <= csr_write_data[rcc_pkg::SIZE_W-1:0];
            end
            rcc_pkg::CSR_FRAME_HEIGHT: begin
               height_ff <= csr_write_data[rcc_pkg::SIZE_W-1:0];
            end
            rcc_pkg::CSR_KROW_TOP: begin
               krow_ff[0] <= csr_write_data;
            end
            rcc_pkg::CSR_KROW_MIDDLE: begin
               krow_ff[1] <= csr_write_data;
            end
            rcc_pkg::CSR_KROW_BOTTOM: begin
               krow_ff[2] <= csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   // zero acts as one, oversize saturates
   assign width_ext  = {{WW{1'b0}}, width_ff};
   assign height_ext = {{HW{1'b0}}, height_ff};
   assign w_eff  = (width_ff == '0) ? WW'(1) :
                   (width_ext > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(width_ext);
   assign h_eff  = (height_ff == '0) ? HW'(1) :
                   (height_ext > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(height_ext);
   assign w_last = w_eff - WW'(1);
   assign h_last = h_eff - HW'(1);

   always_comb begin
      s_col_end   = (WW'(s_col_ff) == w_last);
      s_row_end   = (s_row_ff == SRW'(h_last));
      out_col_end = (WW'(out_col_ff) == w_last);
      out_row_end = (HW'(out_row_ff) == h_last);
      // stream far enough ahead that the window is centered on the next result
      reached   = (HALF == 0) || (s_row_ff > SRW'(1)) ||
                  ((s_row_ff == SRW'(1)) && (s_col_ff != '0));
      pad_req   = (HALF != 0) && rx_done_ff && !reached;
      req_fire  = req_valid && req_ready;
      is_drain  = (req_operation == rcc_pkg::OP_DRAIN);
      push_ok   = req_fire && !is_drain && !rx_done_ff;
      drain_ok  = req_fire && is_drain && rx_done_ff;
      adv       = push_ok || drain_ok || pad_req;
      emit      = drain_ok || (push_ok && reached);
      last_emit = emit && out_row_end && out_col_end;
      last_push = push_ok && s_row_end && s_col_end;
      in_pix    = '{red: req_red_in, green: req_green_in, blue: req_blue_in};
      a_ctl_in.emit      = emit;
      a_ctl_in.last      = last_emit;
      a_ctl_in.top_ok    = (out_row_ff != '0);
      a_ctl_in.bottom_ok = !out_row_end;
      a_ctl_in.left_ok   = (out_col_ff != '0);
      a_ctl_in.right_ok  = !out_col_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_col_ff   <= '0;
         s_row_ff   <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         rx_done_ff <= 1'b0;
      end else if (last_emit) begin
         s_col_ff   <= '0;
         s_row_ff   <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         rx_done_ff <= 1'b0;
      end else begin
         if (adv) begin
            if (s_col_end) begin
               s_col_ff <= '0;
               s_row_ff <= s_row_ff + SRW'(1);
            end else begin
               s_col_ff <= s_col_ff + AW'(1);
            end
         end
         if (emit) begin
            if (out_col_end) begin
               out_col_ff <= '0;
               out_row_ff <= out_row_ff + RW'(1);
            end else begin
               out_col_ff <= out_col_ff + AW'(1);
            end
         end
         if (last_push) begin
            rx_done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_adv_ff <= 1'b0;
         a_ctl_ff <= '0;
      end else begin
         a_adv_ff <= adv;
         a_ctl_ff <= a_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      a_pix_ff <= push_ok ? in_pix : '0;
      a_col_ff <= s_col_ff;
   end

   rcc_line_buf #(
      .DEPTH (MAX_WIDTH)
   ) u_line_buf (
      .clock     (clock),
      .rd_en     (adv),
      .rd_addr   (s_col_ff),
      .wr_en     (a_adv_ff),
      .wr_addr   (a_col_ff),
      .wr_pixel  (a_pix_ff),
      .rd_upper  (lb_upper),
      .rd_middle (lb_middle)
   );

   rcc_tap_mult #(
      .KSIZE (KSIZE)
   ) u_tap_mult (
      .clock      (clock),
      .reset      (reset),
      .shift_en   (a_adv_ff),
      .col_upper  (lb_upper),
      .col_middle (lb_middle),
      .col_lower  (a_pix_ff),
      .ctl_in     (a_ctl_ff),
      .kernel     (krow_ff),
      .stage_emit (b_emit),
      .ctl_out    (c_ctl),
      .products   (products)
   );

   rcc_sum_clamp u_sum_clamp (
      .products (products),
      .result   (sum_pixel)
   );

   assign q_push_data = '{pixel: sum_pixel, last: c_ctl.last};

   rcc_out_queue #(
      .DEPTH (rcc_pkg::QUEUE_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (c_ctl.emit),
      .push_data (q_push_data),
      .pop       (rsp_valid && rsp_ready),
      .head      (q_head),
      .not_empty (rsp_valid),
      .count     (q_count)
   );

   // queue entries plus results still in the pipeline
   assign occupancy = OCW'(q_count) + OCW'(a_ctl_ff.emit) + OCW'(b_emit) + OCW'(c_ctl.emit);
   assign req_ready = !pad_req && (occupancy < OCW'(rcc_pkg::QUEUE_DEPTH));

   assign rsp_red_out   = q_head.pixel.red;
   assign rsp_green_out = q_head.pixel.green;
   assign rsp_blue_out  = q_head.pixel.blue;
   assign rsp_frame_end = q_head.last;

endmodule

// ===== bench/rgb_convolution_clamp_tb.sv =====
// rgb_convolution_clamp_tb: self-checking bench for the 3x3 RGB convolution with clamp
// a predictor of its own rebuilds every filtered pixel; depends on rcc_pkg and the block
module rgb_convolution_clamp_tb;

   localparam int MAX_SIZE      = rcc_pkg::DEF_MAX_WIDTH;
   localparam int HISTORY_DEPTH = 2 * MAX_SIZE + 4;
   localparam int RANDOM_ITEMS  = 500;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT   = 600000;

   typedef struct packed {
      logic               op;
      rcc_pkg::pixel_type px;
   } request_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic                              req_operation = rcc_pkg::OP_PUSH;
   logic [rcc_pkg::CHAN_W-1:0]        req_red_in = '0;
   logic [rcc_pkg::CHAN_W-1:0]        req_green_in = '0;
   logic [rcc_pkg::CHAN_W-1:0]        req_blue_in = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic [rcc_pkg::CHAN_W-1:0]        rsp_red_out;
   logic [rcc_pkg::CHAN_W-1:0]        rsp_green_out;
   logic [rcc_pkg::CHAN_W-1:0]        rsp_blue_out;
   logic                              rsp_frame_end;
   logic                              csr_write_enable = 1'b0;
   logic [rcc_pkg::CSR_INDEX_W-1:0]   csr_index = '0;
   logic [rcc_pkg::CFG_W-1:0]         csr_write_data = '0;

   // predictor state
   logic [rcc_pkg::SIZE_W-1:0] cfg_width  = rcc_pkg::WIDTH_RESET;
   logic [rcc_pkg::SIZE_W-1:0] cfg_height = rcc_pkg::HEIGHT_RESET;
   logic [rcc_pkg::CFG_W-1:0]  kernel_rows [3] = '{rcc_pkg::KROW_TOP_RESET,
                                                   rcc_pkg::KROW_MIDDLE_RESET,
                                                   rcc_pkg::KROW_BOTTOM_RESET};
   rcc_pkg::pixel_type         pixel_history [HISTORY_DEPTH];
   int                         pixels_in  = 0;
   int                         pixels_out = 0;

   request_item_type     pending_requests [$];
   rcc_pkg::result_type  expected_pixels [$];
   bit                   req_taken = 1'b0;
   int                   sender_gap_pct = 0;
   int                   receiver_gap_pct = 0;
   int                   frame_items = 0;
   int                   error_count = 0;
   int                   cycle_count = 0;

   rgb_convolution_clamp i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_frame_end    (rsp_frame_end),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int effective_size(input logic [rcc_pkg::SIZE_W-1:0] value);
      if (value == 0) return 1;
      if (value > MAX_SIZE) return MAX_SIZE;
      return int'(value);
   endfunction

   function automatic logic [rcc_pkg::CHAN_W-1:0] saturate_channel(input longint acc);
      if (acc < 0) return '0;
      if ((acc >>> rcc_pkg::FRAC_BITS) > 255) return rcc_pkg::PIX_MAX;
      return acc[rcc_pkg::FRAC_BITS +: rcc_pkg::CHAN_W];
   endfunction

   function automatic rcc_pkg::result_type convolve_next(input int w, input int h,
                                                         input int total);
      longint              acc_r, acc_g, acc_b;
      int                  row, col, rr, cc, q;
      rcc_pkg::pixel_type  pix;
      rcc_pkg::result_type res;
      row = pixels_out / w;
      col = pixels_out % w;
      acc_r = 0;
      acc_g = 0;
      acc_b = 0;
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            rr = row + dr;
            cc = col + dc;
            if (rr < 0 || cc < 0 || rr >= h || cc >= w) continue;
            pix = pixel_history[(rr * w + cc) % HISTORY_DEPTH];
            q = $signed(kernel_rows[dr + 1][16 * (dc + 1) +: 16]);
            acc_r += longint'(pix.red) * q;
            acc_g += longint'(pix.green) * q;
            acc_b += longint'(pix.blue) * q;
         end
      end
      res.pixel.red   = saturate_channel(acc_r);
      res.pixel.green = saturate_channel(acc_g);
      res.pixel.blue  = saturate_channel(acc_b);
      pixels_out++;
      res.last = 1'b0;
      if (pixels_out >= total) begin
         res.last   = 1'b1;
         pixels_out = 0;
         pixels_in  = 0;
      end
      return res;
   endfunction

   function automatic bit filter_pixel(input request_item_type item,
                                       output rcc_pkg::result_type res);
      int w, h, total;
      w = effective_size(cfg_width);
      h = effective_size(cfg_height);
      total = w * h;
      res = '0;
      if (pixels_out >= total) begin
         pixels_out = 0;
         pixels_in  = 0;
      end
      if (item.op == rcc_pkg::OP_PUSH) begin
         if (pixels_in >= total) return 1'b0;
         pixel_history[pixels_in % HISTORY_DEPTH] = item.px;
         pixels_in++;
         if (pixels_in > pixels_out + w + 1) begin
            res = convolve_next(w, h, total);
            return 1'b1;
         end
         return 1'b0;
      end
      if (pixels_in >= total && pixels_out < total) begin
         res = convolve_next(w, h, total);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic report_error(input string msg);
      if (error_count < 100) $display("ERROR cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // request driver and response stall
   always @(negedge clock) begin
      request_item_type item;
      rsp_ready <= ($urandom_range(0, 99) >= receiver_gap_pct);
      if (!req_valid || req_taken) begin
         if (!reset && pending_requests.size() != 0 &&
             $urandom_range(0, 99) >= sender_gap_pct) begin
            item = pending_requests.pop_front();
            req_valid     <= 1'b1;
            req_operation <= item.op;
            req_red_in    <= item.px.red;
            req_green_in  <= item.px.green;
            req_blue_in   <= item.px.blue;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // prediction on accepted requests, check on accepted results
   always @(posedge clock) begin
      request_item_type    item;
      rcc_pkg::result_type want, got;
      req_taken = !reset && req_valid && req_ready;
      if (req_taken) begin
         item.op = req_operation;
         item.px = {req_red_in, req_green_in, req_blue_in};
         if (filter_pixel(item, want)) expected_pixels.push_back(want);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         got.pixel = {rsp_red_out, rsp_green_out, rsp_blue_out};
         got.last  = rsp_frame_end;
         if (expected_pixels.size() == 0) begin
            report_error($sformatf("unexpected result %h/%h/%h end %b", got.pixel.red,
                                   got.pixel.green, got.pixel.blue, got.last));
         end else begin
            want = expected_pixels.pop_front();
            if (got !== want) begin
               report_error($sformatf("got %h/%h/%h end %b, expected %h/%h/%h end %b",
                                      got.pixel.red, got.pixel.green, got.pixel.blue,
                                      got.last, want.pixel.red, want.pixel.green,
                                      want.pixel.blue, want.last));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic csr_write(input logic [rcc_pkg::CSR_INDEX_W-1:0] index,
                            input logic [rcc_pkg::CFG_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      case (index)
         rcc_pkg::CSR_FRAME_WIDTH: begin
            cfg_width = data[rcc_pkg::SIZE_W-1:0];
         end
         rcc_pkg::CSR_FRAME_HEIGHT: begin
            cfg_height = data[rcc_pkg::SIZE_W-1:0];
         end
         rcc_pkg::CSR_KROW_TOP: begin
            kernel_rows[0] = data;
         end
         rcc_pkg::CSR_KROW_MIDDLE: begin
            kernel_rows[1] = data;
         end
         rcc_pkg::CSR_KROW_BOTTOM: begin
            kernel_rows[2] = data;
         end
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic queue_push(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      request_item_type item;
      item.op = rcc_pkg::OP_PUSH;
      item.px = {r, g, b};
      pending_requests.push_back(item);
   endtask

   task automatic queue_drain();
      request_item_type item;
      item.op = rcc_pkg::OP_DRAIN;
      item.px = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255))};
      pending_requests.push_back(item);
   endtask

   function automatic logic [7:0] random_channel();
      case ($urandom_range(0, 7))
         0: begin
            return 8'h00;
         end
         1: begin
            return 8'hFF;
         end
         default: begin
            return 8'($urandom_range(0, 255));
         end
      endcase
   endfunction

   function automatic logic [rcc_pkg::CFG_W-1:0] random_kernel_row(input int kind);
      logic [rcc_pkg::CFG_W-1:0] row;
      logic [15:0]               picks [5] = '{16'h0000, 16'h0800, 16'h7FFF,
                                               16'h8000, 16'hFFFF};
      for (int k = 0; k < 3; k++) begin
         case (kind)
            0: begin
               row[16 * k +: 16] = 16'($urandom_range(0, 65535));
            end
            1: begin
               row[16 * k +: 16] = 16'($urandom_range(0, 2047)) - 16'd512;
            end
            default: begin
               row[16 * k +: 16] = picks[$urandom_range(0, 4)];
            end
         endcase
      end
      return row;
   endfunction

   // one complete frame; noise adds early drains, pushes past the frame and idle drains
   task automatic add_frame(input int w, input int h, input bit noise);
      int n, drains;
      n = w * h;
      drains = (n < w + 1) ? n : w + 1;
      for (int i = 0; i < n; i++) begin
         if (noise && $urandom_range(0, 11) == 0) queue_drain();
         queue_push(random_channel(), random_channel(), random_channel());
      end
      for (int i = 0; i < drains; i++) begin
         if (noise && $urandom_range(0, 11) == 0) begin
            queue_push(random_channel(), random_channel(), random_channel());
         end
         queue_drain();
      end
      if (noise && $urandom_range(0, 3) == 0) queue_drain();
      frame_items += n + drains;
   endtask

   task automatic wait_quiet();
      while (pending_requests.size() != 0 || req_valid) @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int w, h, kind, era;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      sender_gap_pct   = 37;
      receiver_gap_pct = 82;

      // identity kernel on a 3x3 frame with corner values
      csr_write(rcc_pkg::CSR_FRAME_WIDTH, 48'd3);
      csr_write(rcc_pkg::CSR_FRAME_HEIGHT, 48'd3);
      csr_write(rcc_pkg::CSR_KROW_TOP, 48'd0);
      csr_write(rcc_pkg::CSR_KROW_MIDDLE, 48'h0000_0800_0000);
      csr_write(rcc_pkg::CSR_KROW_BOTTOM, 48'd0);
      queue_drain();
      queue_push(8'h00, 8'h00, 8'h00);
      queue_push(8'hFF, 8'hFF, 8'hFF);
      queue_push(8'hAA, 8'h55, 8'h0F);
      queue_push(8'h55, 8'hAA, 8'hF0);
      queue_push(8'h80, 8'h01, 8'hFE);
      queue_push(8'h01, 8'h80, 8'h7F);
      queue_push(8'hFF, 8'h00, 8'hFF);
      queue_push(8'h00, 8'hFF, 8'h00);
      queue_push(8'h12, 8'h34, 8'h56);
      queue_push(8'hFF, 8'hFF, 8'hFF);
      repeat (4) queue_drain();
      wait_quiet();

      // zero width acts as one, largest positive taps saturate high
      csr_write(rcc_pkg::CSR_FRAME_WIDTH, 48'd0);
      csr_write(rcc_pkg::CSR_FRAME_HEIGHT, 48'd2);
      csr_write(rcc_pkg::CSR_KROW_TOP, 48'h7FFF_7FFF_7FFF);
      csr_write(rcc_pkg::CSR_KROW_MIDDLE, 48'h7FFF_7FFF_7FFF);
      csr_write(rcc_pkg::CSR_KROW_BOTTOM, 48'h7FFF_7FFF_7FFF);
      add_frame(1, 2, 1'b0);
      wait_quiet();

      // most negative taps clamp to zero
      csr_write(rcc_pkg::CSR_FRAME_WIDTH, 48'd2);
      csr_write(rcc_pkg::CSR_FRAME_HEIGHT, 48'd1);
      csr_write(rcc_pkg::CSR_KROW_TOP, 48'h8000_8000_8000);
      csr_write(rcc_pkg::CSR_KROW_MIDDLE, 48'h8000_8000_8000);
      csr_write(rcc_pkg::CSR_KROW_BOTTOM, 48'h8000_8000_8000);
      add_frame(2, 1, 1'b0);
      wait_quiet();

      // wide row with zero height, then a tall single column
      csr_write(rcc_pkg::CSR_FRAME_WIDTH, 48'd96);
      csr_write(rcc_pkg::CSR_FRAME_HEIGHT, 48'd0);
      csr_write(rcc_pkg::CSR_KROW_TOP, random_kernel_row(1));
      csr_write(rcc_pkg::CSR_KROW_MIDDLE, random_kernel_row(1));
      csr_write(rcc_pkg::CSR_KROW_BOTTOM, random_kernel_row(1));
      add_frame(96, 1, 1'b1);
      wait_quiet();
      csr_write(rcc_pkg::CSR_FRAME_WIDTH, 48'd1);
      csr_write(rcc_pkg::CSR_FRAME_HEIGHT, 48'd120);
      add_frame(1, 120, 1'b1);
      wait_quiet();

      frame_items = 0;
      while (frame_items < RANDOM_ITEMS) begin
         era = frame_items * 3 / RANDOM_ITEMS;
         sender_gap_pct   = (era == 0) ? 37 : (era == 1) ? 82 : 0;
         receiver_gap_pct = (era == 0) ? 82 : (era == 1) ? 37 : 0;
         w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
         h = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 6);
         csr_write(rcc_pkg::CSR_FRAME_WIDTH, rcc_pkg::CFG_W'(w));
         csr_write(rcc_pkg::CSR_FRAME_HEIGHT, rcc_pkg::CFG_W'(h));
         kind = $urandom_range(0, 2);
         if ($urandom_range(0, 1)) csr_write(rcc_pkg::CSR_KROW_TOP, random_kernel_row(kind));
         if ($urandom_range(0, 1)) begin
            csr_write(rcc_pkg::CSR_KROW_MIDDLE, random_kernel_row(kind));
         end
         if ($urandom_range(0, 1)) begin
            csr_write(rcc_pkg::CSR_KROW_BOTTOM, random_kernel_row(kind));
         end
         repeat ($urandom_range(1, 3)) add_frame(w, h, 1'b1);
         wait_quiet();
      end

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
